FILE: rtl/core/kalman_angle_bias_filter_core_macros.svh
// Assertion macros for the angle and bias filter core
`ifndef KALMAN_ANGLE_BIAS_FILTER_CORE_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_CORE_MACROS_SVH

// implication checked at every clock edge outside reset
`define KAB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define KAB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/kab_pkg.sv
// Shared types, constants and helpers for the angle and bias filter core
package kab_pkg;

    localparam int unsigned CHANNEL_COUNT_DEF = 2;
    localparam int unsigned CFG_W = 31;
    localparam int unsigned MEAS_W = 24;
    localparam int unsigned RATE_W = 25;

    localparam logic [30:0] DT_RST = 31'd10737418;
    localparam logic [30:0] QA_RST = 31'd214748;
    localparam logic [30:0] QB_RST = 31'd1610613;
    localparam logic [30:0] R_RST  = 31'd322122547;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [63:0] MIN_DENOM = 64'd1074;

    // register addresses (word index)
    localparam logic [1:0] REG_DT = 2'd0;
    localparam logic [1:0] REG_QA = 2'd1;
    localparam logic [1:0] REG_QB = 2'd2;
    localparam logic [1:0] REG_R  = 2'd3;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] quo;
    } div_rsp_t;

    function automatic logic signed [63:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -66'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v[63:0];
    endfunction

endpackage

FILE: rtl/core/kalman_angle_bias_filter_core.sv
// Top level of the two-state angle and gyro bias filter core
//   channel  dir  bus                 content
//   s_axis   in   tvalid/tready/tdata one sample, channel in tuser
//   m_axis   out  tvalid/tready/tdata filtered angle, channel in tuser
//   apb      in   psel/penable/...    four filter registers
// m_tvalid rises once the sequencer is done with a transfer in: nine passes through the
// shared multiplier and two 63-step divisions, each awaited through its done strobe.
// Below the denominator floor the divisions and the measurement update are skipped;
// a channel beyond the count skips the sequencer and gives a zero result.
// Reset is synchronous and active low and restores the state and registers.
// s_tready is low from acceptance until the result has been taken.
module kalman_angle_bias_filter_core #(
    parameter int unsigned CHANNEL_COUNT = kab_pkg::CHANNEL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [23:0] measured_angle, [48:24] angular_rate
    input  logic [0:0]  s_tuser,   // [0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] filtered_angle
    output logic [0:0]  m_tuser,   // [0] channel_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [30:0] dt_reg, qa_reg, qb_reg, r_reg;
    logic busy_reg, skip_reg, outv_reg, ch_reg;
    logic [31:0] out_reg;
    logic start, sdone, wr;
    logic signed [31:0] sangle;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    assign s_tready = ~busy_reg;
    assign start = s_tvalid & ~busy_reg & (32'(s_tuser) < CHANNEL_COUNT);

    always_comb begin
        unique case (paddr[3:2])
            kab_pkg::REG_DT: prdata = {1'b0, dt_reg};
            kab_pkg::REG_QA: prdata = {1'b0, qa_reg};
            kab_pkg::REG_QB: prdata = {1'b0, qb_reg};
            kab_pkg::REG_R:  prdata = {1'b0, r_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= kab_pkg::DT_RST;
            qa_reg <= kab_pkg::QA_RST;
            qb_reg <= kab_pkg::QB_RST;
            r_reg  <= kab_pkg::R_RST;
        end else if (wr) begin
            unique case (paddr[3:2])
                kab_pkg::REG_DT: dt_reg <= pwdata[30:0];
                kab_pkg::REG_QA: qa_reg <= pwdata[30:0];
                kab_pkg::REG_QB: qb_reg <= pwdata[30:0];
                kab_pkg::REG_R:  r_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    kab_seq #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(start), .ch_in(s_tuser[0]),
        .meas_in(s_tdata[23:0]), .rate_in(s_tdata[48:24]),
        .dt(dt_reg), .qa(qa_reg), .qb(qb_reg), .rn(r_reg),
        .done(sdone), .angle_out(sangle)
    );

    // busy from transfer in until the result transfer out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            skip_reg <= 1'b0;
            outv_reg <= 1'b0;
        end else begin
            skip_reg <= 1'b0;
            if (s_tvalid && !busy_reg) begin
                busy_reg <= 1'b1;
                ch_reg   <= s_tuser[0];
                skip_reg <= ~start;
            end
            if (sdone || skip_reg) begin
                outv_reg <= 1'b1;
                out_reg  <= skip_reg ? 32'd0 : sangle;
            end
            if (outv_reg && m_tready) begin
                outv_reg <= 1'b0;
                busy_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = ch_reg;
endmodule

FILE: rtl/core/kab_mul.sv
// Shared 32x32 multiplier with round-half-up shift by 30, registered
module kab_mul (
    input  logic               aclk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);
    logic signed [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign p = (prod_reg + 64'sd536870912) >>> 30;
endmodule

FILE: rtl/core/kab_div.sv
// Restoring divider, one quotient bit per cycle, truncates toward zero
module kab_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  kab_pkg::div_req_t  req,
    output kab_pkg::div_rsp_t  rsp
);
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg, neg_reg;
    logic [62:0] num_reg;
    logic [32:0] den_reg;
    logic [33:0] rem_reg;
    logic [62:0] quo_reg;
    logic [33:0] trial;
    logic [63:0] nabs, dabs;

    assign nabs = req.num[63] ? 64'(-req.num) : 64'(req.num);
    assign dabs = req.den[63] ? 64'(-req.den) : 64'(req.den);
    assign trial = {rem_reg[32:0], num_reg[62]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd63;
                num_reg  <= nabs[62:0];
                den_reg  <= dabs[32:0];
                rem_reg  <= '0;
                neg_reg  <= req.num[63] ^ req.den[63];
            end else if (busy_reg) begin
                num_reg <= {num_reg[61:0], 1'b0};
                if (!trial[33]) begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[61:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[32:0], num_reg[62]};
                    quo_reg <= {quo_reg[61:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
endmodule

FILE: rtl/core/kab_seq.sv
// Sequencer: holds filter state and steps one update through the shared units
module kab_seq #(
    parameter int unsigned CHANNEL_COUNT = kab_pkg::CHANNEL_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               ch_in,
    input  logic signed [23:0] meas_in,
    input  logic signed [24:0] rate_in,
    input  logic [30:0]        dt,
    input  logic [30:0]        qa,
    input  logic [30:0]        qb,
    input  logic [30:0]        rn,
    output logic               done,
    output logic signed [31:0] angle_out
);
    localparam int unsigned CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M0W, S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W,
        S_DEN, S_D0, S_D0W, S_D1, S_D1W,
        S_U0, S_U0W, S_U1, S_U1W, S_U2, S_U2W, S_U3, S_U3W, S_U4, S_U4W, S_WB
    } state_t;

    state_t state_reg;
    logic signed [31:0] ang_mem [CHANNEL_COUNT];
    logic signed [31:0] bias_mem [CHANNEL_COUNT];
    logic signed [31:0] p00_mem [CHANNEL_COUNT];
    logic signed [31:0] p01_mem [CHANNEL_COUNT];
    logic signed [31:0] p11_mem [CHANNEL_COUNT];

    logic [CW-1:0] ch_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p11_reg, diff_reg;
    logic signed [31:0] k0_reg, k1_reg, err_reg, c_reg, meas_reg;
    logic signed [63:0] acc_reg, den_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] mp;
    logic done_reg;
    kab_pkg::div_req_t dreq;
    kab_pkg::div_rsp_t drsp;
    logic [63:0] aden;
    logic signed [31:0] dts;

    assign dts = $signed({1'b0, dt});

    kab_mul u_mul (.aclk(aclk), .a(ma), .b(mb), .p(mp));
    kab_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    assign aden = den_reg[63] ? 64'(-den_reg) : 64'(den_reg);

    always_comb begin
        ma = dts;
        mb = diff_reg;
        dreq.start = 1'b0;
        dreq.num = {{32{p00_reg[31]}}, p00_reg} <<< 30;
        dreq.den = den_reg;
        case (state_reg)
            S_M1:    mb = p11_reg;
            S_M2:    mb = p01_reg;
            S_M3:    mb = c_reg;
            S_D0:    dreq.start = 1'b1;
            S_D1: begin
                dreq.start = 1'b1;
                dreq.num = {{32{p01_reg[31]}}, p01_reg} <<< 30;
            end
            S_U0: begin ma = k0_reg; mb = err_reg; end
            S_U1: begin ma = k1_reg; mb = err_reg; end
            S_U2: begin ma = k0_reg; mb = p00_reg; end
            S_U3: begin ma = k0_reg; mb = p01_reg; end
            S_U4: begin ma = k1_reg; mb = p01_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < int'(CHANNEL_COUNT); i++) begin
                ang_mem[i]  <= '0;
                bias_mem[i] <= '0;
                p00_mem[i]  <= kab_pkg::ONE_Q30;
                p01_mem[i]  <= '0;
                p11_mem[i]  <= kab_pkg::ONE_Q30;
            end
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (start) begin
                    ch_reg   <= CW'(ch_in);
                    meas_reg <= 32'(meas_in);
                    ang_reg  <= ang_mem[CW'(ch_in)];
                    bias_reg <= bias_mem[CW'(ch_in)];
                    p00_reg  <= p00_mem[CW'(ch_in)];
                    p01_reg  <= p01_mem[CW'(ch_in)];
                    p11_reg  <= p11_mem[CW'(ch_in)];
                    diff_reg <= 32'(kab_pkg::sat32(66'(rate_in) -
                                66'(bias_mem[CW'(ch_in)])));
                    state_reg <= S_M0;
                end
                S_M0:  state_reg <= S_M0W;
                S_M0W: begin
                    ang_reg <= 32'(kab_pkg::sat32(66'(ang_reg) + 66'(mp)));
                    state_reg <= S_M1;
                end
                S_M1:  state_reg <= S_M1W;
                S_M1W: begin
                    c_reg <= 32'(kab_pkg::sat32(66'(p01_reg) - 66'(mp)));
                    state_reg <= S_M2;
                end
                S_M2:  state_reg <= S_M2W;
                S_M2W: begin
                    acc_reg <= 64'(p00_reg) - mp + 64'(qa);
                    state_reg <= S_M3;
                end
                S_M3:  state_reg <= S_M3W;
                S_M3W: begin
                    p00_reg <= 32'(kab_pkg::sat32(66'(acc_reg) - 66'(mp)));
                    den_reg <= 64'(kab_pkg::sat32(66'(acc_reg) - 66'(mp))) + 64'(rn);
                    p01_reg <= c_reg;
                    p11_reg <= 32'(kab_pkg::sat32(66'(p11_reg) + 66'(qb)));
                    state_reg <= S_DEN;
                end
                S_DEN: state_reg <= (aden >= kab_pkg::MIN_DENOM) ? S_D0 : S_WB;
                S_D0:  state_reg <= S_D0W;
                S_D0W: if (drsp.done) begin
                    k0_reg <= 32'(kab_pkg::sat32(66'(drsp.quo)));
                    state_reg <= S_D1;
                end
                S_D1:  state_reg <= S_D1W;
                S_D1W: if (drsp.done) begin
                    k1_reg <= 32'(kab_pkg::sat32(66'(drsp.quo)));
                    err_reg <= 32'(kab_pkg::sat32(66'(meas_reg) - 66'(ang_reg)));
                    state_reg <= S_U0;
                end
                S_U0:  state_reg <= S_U0W;
                S_U0W: begin
                    ang_reg <= 32'(kab_pkg::sat32(66'(ang_reg) + 66'(mp)));
                    state_reg <= S_U1;
                end
                S_U1:  state_reg <= S_U1W;
                S_U1W: begin
                    bias_reg <= 32'(kab_pkg::sat32(66'(bias_reg) + 66'(mp)));
                    state_reg <= S_U2;
                end
                S_U2:  state_reg <= S_U2W;
                S_U2W: begin
                    p00_reg <= 32'(kab_pkg::sat32(66'(p00_reg) - 66'(mp)));
                    state_reg <= S_U3;
                end
                S_U3:  state_reg <= S_U3W;
                S_U3W: begin
                    c_reg <= 32'(kab_pkg::sat32(66'(p01_reg) - 66'(mp)));
                    state_reg <= S_U4;
                end
                S_U4:  state_reg <= S_U4W;
                S_U4W: begin
                    // P11 uses the cross term from before its own update
                    p11_reg <= 32'(kab_pkg::sat32(66'(p11_reg) - 66'(mp)));
                    p01_reg <= c_reg;
                    state_reg <= S_WB;
                end
                S_WB: begin
                    ang_mem[ch_reg]  <= ang_reg;
                    bias_mem[ch_reg] <= bias_reg;
                    p00_mem[ch_reg]  <= p00_reg;
                    p01_mem[ch_reg]  <= p01_reg;
                    p11_mem[ch_reg]  <= p11_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign angle_out = ang_reg;
endmodule

FILE: rtl/core/kab_checker.sv
// Port-level checker for the filter core, bound to the top level
`include "kalman_angle_bias_filter_core_macros.svh"
module kab_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);
    `KAB_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, m_tvalid, !s_tready, "input taken while result pending")
    `KAB_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready after transfer in")
    `KAB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `KAB_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready, "pready low")
endmodule

bind kalman_angle_bias_filter_core kab_checker u_kab_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
